@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the pixel tint block.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PPHSV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PPHSV_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PPHSV_ASSERT(lbl, clk, rstn, prop, msg)
`define PPHSV_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ rtl/pphsv_pkg.sv @@
// Package for the pixel premultiply and HSV tint block.
// Holds register codes, shared types, constants and small arithmetic helpers.
`timescale 1ns / 1ps

package pphsv_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned CoefLatency = 5;

  localparam logic [CfgW-1:0] HueMax = 7'd102;
  localparam logic [CfgW-1:0] SatMax = 7'd102;

  localparam logic [1:0] RegTintEnable = 2'd0;
  localparam logic [1:0] RegThemeHue   = 2'd1;
  localparam logic [1:0] RegThemeSat   = 2'd2;
  localparam logic [1:0] RegThemeLight = 2'd3;

  // Reciprocal constants for exact floor division over the stated ranges.
  localparam logic [9:0]  RecipDiv60   = 10'd547;     // x < 2^9,  shift 15
  localparam logic [15:0] RecipDiv3    = 16'd43691;   // x < 2^15, shift 17
  localparam logic [18:0] RecipDiv1000 = 19'd268436;  // x < 2^18, shift 28
  localparam logic [9:0]  RecipAvg3    = 10'd683;     // x <= 765, shift 11

  // Smallest product whose floor by 255 exceeds 255.
  localparam logic [16:0] VClampLimit = 17'd65280;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } pphsv_sector_e;

  typedef struct packed {
    logic            tint_en;
    logic [CfgW-1:0] hue;
    logic [CfgW-1:0] sat;
    logic [CfgW-1:0] light;
  } pphsv_cfg_t;

  typedef struct packed {
    pphsv_sector_e    sector;
    logic [ChanW-1:0] fa;
    logic [ChanW-1:0] fb;
    logic [ChanW-1:0] fc;
  } pphsv_coef_t;

  // Exact floor(x / 255) for any x up to 65279.
  function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [12:0] sector_base(input pphsv_sector_e s);
    logic [12:0] b;
    case (s)
      SecRed:     b = 13'd0;
      SecYellow:  b = 13'd1000;
      SecGreen:   b = 13'd2000;
      SecCyan:    b = 13'd3000;
      SecBlue:    b = 13'd4000;
      SecMagenta: b = 13'd5000;
      default:    b = 13'd0;
    endcase
    return b;
  endfunction

  // floor(x * 3 / 2) clamped to one byte.
  function automatic logic [ChanW-1:0] boost(input logic [ChanW-1:0] x);
    logic [9:0] t;
    t = ({2'b00, x} + {1'b0, x, 1'b0}) >> 1;
    return (t > 10'd255) ? 8'hFF : t[7:0];
  endfunction

endpackage

@@ rtl/pphsv_coef.sv @@
// Theme coefficient pipeline: turns hue and saturation settings into the sector
// and the three V scale factors. Depends on pphsv_pkg.
`timescale 1ns / 1ps

module pphsv_coef (
  input  logic                clk_i,
  input  pphsv_pkg::pphsv_cfg_t cfg_i,
  output pphsv_pkg::pphsv_coef_t coef_o
);

  logic [6:0]  hs, ss;
  logic [9:0]  hmul7;
  logic [9:0]  smul5;
  logic [8:0]  h1_q;
  logic [7:0]  s1_q, s2_q, s3_q, s4_q;
  logic [18:0] pdiv;
  logic [14:0] h50;
  logic [2:0]  p2_q;
  logic [14:0] h50_q;
  logic [30:0] qprod;
  pphsv_pkg::pphsv_sector_e p3_q, p4_q;
  logic [12:0] q3_q;
  logic [12:0] fdiff;
  logic [9:0]  f;
  logic [17:0] pb4_q, pc4_q;
  logic [36:0] tbprod, tcprod;
  pphsv_pkg::pphsv_coef_t coef_q;

  always_comb begin
    hs    = (cfg_i.hue > pphsv_pkg::HueMax) ? pphsv_pkg::HueMax : cfg_i.hue;
    ss    = (cfg_i.sat > pphsv_pkg::SatMax) ? pphsv_pkg::SatMax : cfg_i.sat;
    hmul7 = 10'(hs) * 10'd7;
    smul5 = 10'(ss) * 10'd5;
    pdiv  = 19'(h1_q) * 19'(pphsv_pkg::RecipDiv60);
    h50   = 15'(h1_q) * 15'd50;
    qprod = 31'(h50_q) * 31'(pphsv_pkg::RecipDiv3);
    fdiff = q3_q - pphsv_pkg::sector_base(p3_q);
    f     = fdiff[9:0];
    tbprod = 37'(pb4_q) * 37'(pphsv_pkg::RecipDiv1000);
    tcprod = 37'(pc4_q) * 37'(pphsv_pkg::RecipDiv1000);
  end

  always_ff @(posedge clk_i) begin
    h1_q  <= hmul7[9:1];
    s1_q  <= smul5[8:1];
    p2_q  <= pdiv[17:15];
    h50_q <= h50;
    s2_q  <= s1_q;
    p3_q  <= pphsv_pkg::pphsv_sector_e'(p2_q);
    q3_q  <= qprod[29:17];
    s3_q  <= s2_q;
    p4_q  <= p3_q;
    s4_q  <= s3_q;
    pb4_q <= 18'(s3_q) * 18'(f);
    pc4_q <= 18'(s3_q) * 18'(10'd1000 - f);
    coef_q.sector <= p4_q;
    coef_q.fa     <= 8'd255 - s4_q;
    coef_q.fb     <= 8'd255 - tbprod[35:28];
    coef_q.fc     <= 8'd255 - tcprod[35:28];
  end

  assign coef_o = coef_q;

endmodule

@@ rtl/pphsv_datapath.sv @@
// Seven-stage pixel pipeline: alpha premultiply, average, V, HSV channels, boost.
// Depends on pphsv_pkg and the coefficients from pphsv_coef.
`timescale 1ns / 1ps

module pphsv_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   in_valid_i,
  input  logic [31:0]            in_pixel_i,
  input  pphsv_pkg::pphsv_cfg_t  cfg_i,
  input  pphsv_pkg::pphsv_coef_t coef_i,
  output logic                   out_valid_o,
  output logic [31:0]            out_pixel_o
);

  logic [7:1]  vld_q;

  logic [15:0] mb1_q, mg1_q, mr1_q;
  logic [7:0]  a1_q;
  logic [7:0]  b2_q, g2_q, r2_q, a2_q;
  logic [9:0]  sum2_q;
  logic [7:0]  b3_q, g3_q, r3_q, a3_q, avg3_q;
  logic [7:0]  b4_q, g4_q, r4_q, a4_q;
  logic [16:0] x4_q;
  logic [7:0]  b5_q, g5_q, r5_q, a5_q, v5_q;
  logic [7:0]  b6_q, g6_q, r6_q, a6_q, v6_q;
  logic [15:0] pa6_q, pb6_q, pc6_q;
  pphsv_pkg::pphsv_sector_e sec6_q;
  logic [31:0] out_q;

  logic [7:0]  pb2, pg2, pr2;
  logic [18:0] avgprod;
  logic [8:0]  lscale;
  logic [7:0]  ka, kb, kc;
  logic [7:0]  hr, hg, hb;

  always_comb begin
    pb2     = pphsv_pkg::div255(mb1_q);
    pg2     = pphsv_pkg::div255(mg1_q);
    pr2     = pphsv_pkg::div255(mr1_q);
    avgprod = 19'(sum2_q) * 19'(pphsv_pkg::RecipAvg3);
    lscale  = {1'b0, 8'(cfg_i.light) + 8'd50} << 1;
    ka      = pphsv_pkg::div255(pa6_q);
    kb      = pphsv_pkg::div255(pb6_q);
    kc      = pphsv_pkg::div255(pc6_q);
    case (sec6_q)
      pphsv_pkg::SecRed:    begin hr = v6_q; hg = kc;   hb = ka;   end
      pphsv_pkg::SecYellow: begin hr = kb;   hg = v6_q; hb = ka;   end
      pphsv_pkg::SecGreen:  begin hr = ka;   hg = v6_q; hb = kc;   end
      pphsv_pkg::SecCyan:   begin hr = ka;   hg = kb;   hb = v6_q; end
      pphsv_pkg::SecBlue:   begin hr = kc;   hg = ka;   hb = v6_q; end
      default:              begin hr = v6_q; hg = ka;   hb = kb;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mb1_q  <= 16'(in_pixel_i[7:0])   * 16'(in_pixel_i[31:24]);
      mg1_q  <= 16'(in_pixel_i[15:8])  * 16'(in_pixel_i[31:24]);
      mr1_q  <= 16'(in_pixel_i[23:16]) * 16'(in_pixel_i[31:24]);
      a1_q   <= in_pixel_i[31:24];

      b2_q   <= pb2;
      g2_q   <= pg2;
      r2_q   <= pr2;
      a2_q   <= a1_q;
      sum2_q <= 10'(pb2) + 10'(pg2) + 10'(pr2);

      b3_q   <= b2_q;
      g3_q   <= g2_q;
      r3_q   <= r2_q;
      a3_q   <= a2_q;
      avg3_q <= avgprod[18:11];

      b4_q   <= b3_q;
      g4_q   <= g3_q;
      r4_q   <= r3_q;
      a4_q   <= a3_q;
      x4_q   <= 17'(lscale) * 17'(avg3_q);

      b5_q   <= b4_q;
      g5_q   <= g4_q;
      r5_q   <= r4_q;
      a5_q   <= a4_q;
      v5_q   <= (x4_q >= pphsv_pkg::VClampLimit) ? 8'hFF : pphsv_pkg::div255(x4_q[15:0]);

      b6_q   <= b5_q;
      g6_q   <= g5_q;
      r6_q   <= r5_q;
      a6_q   <= a5_q;
      v6_q   <= v5_q;
      pa6_q  <= 16'(coef_i.fa) * 16'(v5_q);
      pb6_q  <= 16'(coef_i.fb) * 16'(v5_q);
      pc6_q  <= 16'(coef_i.fc) * 16'(v5_q);
      sec6_q <= coef_i.sector;

      if (cfg_i.tint_en) begin
        out_q <= {a6_q, pphsv_pkg::boost(hr), pphsv_pkg::boost(hg), pphsv_pkg::boost(hb)};
      end else begin
        out_q <= {a6_q, r6_q, g6_q, b6_q};
      end
    end
  end

  assign out_valid_o = vld_q[7];
  assign out_pixel_o = out_q;

endmodule

@@ rtl/pixel_premultiply_hsv_tint.sv @@
// Top level of the pixel premultiply and HSV tint block: APB registers, stream
// handshake and the two pipelines. Depends on pphsv_pkg, pphsv_coef, pphsv_datapath.
`timescale 1ns / 1ps

// One BGRA pixel enters per clock while the input side is ready, and its result passes
// through the seven-stage pixel pipeline; throughput is one pixel per clock whenever
// the output side is ready and the coefficients have settled. The whole pipeline
// advances together, so a stalled output beat holds every stage. After any register
// write the input side stays not ready while the theme coefficient pipeline settles.

`include "assert_macros.svh"

module pixel_premultiply_hsv_tint (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // blue_in, green_in, red_in, alpha_in
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // blue_out, green_out, red_out, alpha_out
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pphsv_pkg::AddrW-1:0] paddr,
  input  logic [pphsv_pkg::DataW-1:0] pwdata,
  output logic [pphsv_pkg::DataW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned SettleW = $clog2(pphsv_pkg::CoefLatency + 1);

  pphsv_pkg::pphsv_cfg_t  cfg_q;
  pphsv_pkg::pphsv_coef_t coef;
  logic [SettleW-1:0]     settle_q, settle_d;
  logic                   cfg_wr;
  logic                   pipe_en;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pipe_en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en && (settle_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tint_en <= 1'b0;
      cfg_q.hue     <= 7'd0;
      cfg_q.sat     <= 7'd10;
      cfg_q.light   <= 7'd50;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pphsv_pkg::RegTintEnable: cfg_q.tint_en <= pwdata[0];
        pphsv_pkg::RegThemeHue:   cfg_q.hue     <= pwdata[6:0];
        pphsv_pkg::RegThemeSat:   cfg_q.sat     <= pwdata[6:0];
        pphsv_pkg::RegThemeLight: cfg_q.light   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pphsv_pkg::RegTintEnable: prdata = 32'(cfg_q.tint_en);
      pphsv_pkg::RegThemeHue:   prdata = 32'(cfg_q.hue);
      pphsv_pkg::RegThemeSat:   prdata = 32'(cfg_q.sat);
      pphsv_pkg::RegThemeLight: prdata = 32'(cfg_q.light);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_wr) begin
      settle_d = SettleW'(pphsv_pkg::CoefLatency);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleW'(pphsv_pkg::CoefLatency);
    end else begin
      settle_q <= settle_d;
    end
  end

  pphsv_coef u_coef (
    .clk_i  (clk_i),
    .cfg_i  (cfg_q),
    .coef_o (coef)
  );

  pphsv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (s_axis_tvalid && s_axis_tready),
    .in_pixel_i  (s_axis_tdata),
    .cfg_i       (cfg_q),
    .coef_i      (coef),
    .out_valid_o (m_axis_tvalid),
    .out_pixel_o (m_axis_tdata)
  );

  `PPHSV_NEVER(a_no_accept_settling, clk_i, rst_ni,
               (settle_q != '0) && s_axis_tready, "pixel accepted while coefficients settle")
  `PPHSV_ASSERT(a_write_restarts_settle, clk_i, rst_ni,
                cfg_wr |=> (settle_q == SettleW'(pphsv_pkg::CoefLatency)),
                "settle count not restarted by write")
  `PPHSV_NEVER(a_stall_blocks_input, clk_i, rst_ni,
               m_axis_tvalid && !m_axis_tready && s_axis_tready,
               "input ready while output stalled")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for pixel_premultiply_hsv_tint: drives BGRA beats and theme
// register writes, predicts each output pixel and compares it beat by beat.
// Depends on pphsv_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pphsv_pkg::pphsv_cfg_t theme;
  bgra_t       pending_pixels[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned pixels_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned fail_count = 0;

  pixel_premultiply_hsv_tint uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned clamp_byte(input int unsigned x);
    return (x > 255) ? 255 : x;
  endfunction

  function automatic bgra_t premultiply_and_tint(input bgra_t px,
                                                 input pphsv_pkg::pphsv_cfg_t c);
    int unsigned a, b, g, r, hs, ss, h, s, avg, v, sec, f, ka, kb, kc, hr, hg, hb;
    bgra_t o;
    a = px.alpha;
    b = px.blue * a / 255;
    g = px.green * a / 255;
    r = px.red * a / 255;
    if (c.tint_en) begin
      hs = (c.hue > pphsv_pkg::HueMax) ? pphsv_pkg::HueMax : c.hue;
      ss = (c.sat > pphsv_pkg::SatMax) ? pphsv_pkg::SatMax : c.sat;
      h = hs * 7 / 2;
      s = ss * 5 / 2;
      avg = (b + g + r) / 3;
      v = clamp_byte((c.light + 50) * 2 * avg / 255);
      sec = h / 60;
      f = h * 100 / 6 - sec * 1000;
      ka = (255 - s) * v / 255;
      kb = (255 - s * f / 1000) * v / 255;
      kc = (255 - s * (1000 - f) / 1000) * v / 255;
      case (pphsv_pkg::pphsv_sector_e'(sec[2:0]))
        pphsv_pkg::SecRed: begin
          hr = v;  hg = kc; hb = ka;
        end
        pphsv_pkg::SecYellow: begin
          hr = kb; hg = v;  hb = ka;
        end
        pphsv_pkg::SecGreen: begin
          hr = ka; hg = v;  hb = kc;
        end
        pphsv_pkg::SecCyan: begin
          hr = ka; hg = kb; hb = v;
        end
        pphsv_pkg::SecBlue: begin
          hr = kc; hg = ka; hb = v;
        end
        default: begin
          hr = v;  hg = ka; hb = kb;
        end
      endcase
      r = clamp_byte((hr & 8'hFF) * 15 / 10);
      g = clamp_byte((hg & 8'hFF) * 15 / 10);
      b = clamp_byte((hb & 8'hFF) * 15 / 10);
    end
    o.blue = b[7:0];
    o.green = g[7:0];
    o.red = r[7:0];
    o.alpha = px.alpha;
    return o;
  endfunction

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    bgra_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_pixels.size() == 0) begin
        $error("output beat %h with no pixel outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        beats_checked++;
        if (got.blue !== want.blue) begin
          $error("blue_out mismatch: expected %0d, got %0d", want.blue, got.blue);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("green_out mismatch: expected %0d, got %0d", want.green, got.green);
          fail_count++;
        end
        if (got.red !== want.red) begin
          $error("red_out mismatch: expected %0d, got %0d", want.red, got.red);
          fail_count++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha_out mismatch: expected %0d, got %0d", want.alpha, got.alpha);
          fail_count++;
        end
      end
    end
  end

  task automatic send_pixel(input bgra_t px);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(premultiply_and_tint(px, theme));
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pphsv_pkg::RegTintEnable: theme.tint_en = data[0];
      pphsv_pkg::RegThemeHue:   theme.hue = data[6:0];
      pphsv_pkg::RegThemeSat:   theme.sat = data[6:0];
      default:                  theme.light = data[6:0];
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] val, input int unsigned w);
    logic [31:0] hi;
    hi = $urandom_range(1) ? ($urandom << w) : 32'd0;
    return hi | val;
  endfunction

  task automatic set_theme(input logic en, input int unsigned hue, input int unsigned sat,
                           input int unsigned light);
    wait_drained();
    apb_write(pphsv_pkg::RegTintEnable, with_junk(32'(en), 1));
    apb_write(pphsv_pkg::RegThemeHue, with_junk(32'(hue), pphsv_pkg::CfgW));
    apb_write(pphsv_pkg::RegThemeSat, with_junk(32'(sat), pphsv_pkg::CfgW));
    apb_write(pphsv_pkg::RegThemeLight, with_junk(32'(light), pphsv_pkg::CfgW));
  endtask

  function automatic int unsigned pick_setting(input int unsigned top);
    int unsigned k;
    k = $urandom_range(7);
    if (k == 0) return 0;
    if (k == 1) return top;
    if (k == 2) return 127;
    return $urandom_range(127);
  endfunction

  function automatic bgra_t random_pixel();
    bgra_t px;
    int unsigned k;
    px = $urandom;
    k = $urandom_range(9);
    if (k < 2) px.alpha = 8'h00;
    else if (k < 4) px.alpha = 8'hFF;
    if ($urandom_range(9) == 0) px.red = 8'hFF;
    if ($urandom_range(9) == 0) px.green = 8'hFF;
    if ($urandom_range(9) == 0) px.blue = 8'hFF;
    return px;
  endfunction

  task automatic test_premultiply_at_reset();
    send_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h00, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h01, 8'h01, 8'h80, 8'hFF});
    send_pixel({8'hFE, 8'hFE, 8'h7F, 8'h01});
    send_pixel({8'hFF, 8'h56, 8'h34, 8'h12});
  endtask

  task automatic test_tint_reset_theme();
    wait_drained();
    apb_write(pphsv_pkg::RegTintEnable, 32'd1);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h80, 8'h20, 8'hC0, 8'h60});
  endtask

  task automatic test_tint_sectors();
    int unsigned hues[8] = '{0, 18, 35, 52, 69, 86, 102, 127};
    foreach (hues[i]) begin
      set_theme(1'b1, hues[i], 102, 100);
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    end
  endtask

  task automatic test_tint_extremes();
    set_theme(1'b1, 127, 127, 127);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    set_theme(1'b1, 50, 0, 0);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    set_theme(1'b1, 35, 127, 127);
    send_pixel({8'hFF, 8'h00, 8'h00, 8'h00});
    set_theme(1'b1, 86, 51, 127);
    send_pixel({8'hC0, 8'h80, 8'h80, 8'h80});
  endtask

  task automatic test_random_stream(input int unsigned chunks, input int unsigned per_chunk);
    repeat (chunks) begin
      set_theme($urandom_range(3) != 0, pick_setting(102), pick_setting(102),
                pick_setting(100));
      repeat (per_chunk) send_pixel(random_pixel());
    end
  endtask

  task automatic test_output_backpressure();
    set_theme(1'b1, $urandom_range(102), $urandom_range(102), $urandom_range(100));
    @(posedge clk_i);
    recv_hold = 80;
    repeat (40) send_pixel(random_pixel());
    wait_drained();
  endtask

  initial begin
    theme = '{tint_en: 1'b0, hue: 7'd0, sat: 7'd10, light: 7'd50};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_premultiply_at_reset();
    test_tint_reset_theme();
    test_tint_sectors();
    test_tint_extremes();

    send_idle_pct = 13;
    recv_idle_pct = 64;
    test_random_stream(7, 50);
    test_output_backpressure();
    send_idle_pct = 64;
    recv_idle_pct = 13;
    test_random_stream(7, 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(7, 50);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d pixels and checked %0d output beats across %0d register writes,",
             pixels_sent, beats_checked, reg_writes);
    $display("covering premultiply only, every hue sector and out-of-range theme values.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d pixels outstanding.", pending_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pphsv_pkg.sv
rtl/pphsv_coef.sv
rtl/pphsv_datapath.sv
rtl/pixel_premultiply_hsv_tint.sv
sim/testbench.sv
